// File: hdl/alignment_flag_statistics_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the alignment flag statistics unit.
// Each macro is clocked on the rising edge and is disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef ALIGNMENT_FLAG_STATISTICS_UNIT_ASSERT_SVH
`define ALIGNMENT_FLAG_STATISTICS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define AFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/afs_pkg.sv
// ---------------------------------------------------------------------------
// afs_pkg
// Shared types, constants and helpers of the alignment flag statistics unit.
// ---------------------------------------------------------------------------
`default_nettype none

package afs_pkg;

  localparam int unsigned NUM_COUNTERS = 18;
  localparam int unsigned CNT_W        = 64;
  localparam int unsigned SUM_W        = 32;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned CODE_W       = 4;
  localparam int unsigned CLEN_W       = 28;
  localparam int unsigned FLAGS_W      = 12;
  localparam int unsigned RLEN_W       = 16;
  localparam int unsigned MAPQ_W       = 8;
  localparam int unsigned IDX_W        = 5;

  typedef enum logic [OP_W-1:0] {
    OP_CIGAR  = 2'd0,
    OP_RECORD = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SKIP    = 2'd1,
    ST_BAD_OP  = 2'd2,
    ST_NO_FRAG = 2'd3
  } status_e;

  // Cigar operation codes.
  localparam logic [CODE_W-1:0] CIG_MATCH  = 4'd0;
  localparam logic [CODE_W-1:0] CIG_INSERT = 4'd1;
  localparam logic [CODE_W-1:0] CIG_SKIP   = 4'd3;
  localparam logic [CODE_W-1:0] CIG_PAD    = 4'd6;

  // Flag bit positions.
  localparam int unsigned FL_PAIRED        = 0;
  localparam int unsigned FL_PROPER        = 1;
  localparam int unsigned FL_UNMAPPED      = 2;
  localparam int unsigned FL_MATE_UNMAPPED = 3;
  localparam int unsigned FL_READ1         = 6;
  localparam int unsigned FL_READ2         = 7;
  localparam int unsigned FL_SECONDARY     = 8;
  localparam int unsigned FL_QCFAIL        = 9;
  localparam int unsigned FL_DUP           = 10;
  localparam int unsigned FL_SUPPL         = 11;

  localparam logic [MAPQ_W-1:0] MAPQ_UNKNOWN = 8'd255;

  // Counter positions.
  localparam int unsigned C_R_QCPASS     = 0;
  localparam int unsigned C_R_QCFAIL     = 1;
  localparam int unsigned C_R_PAIRED     = 2;
  localparam int unsigned C_R_SINGLE     = 3;
  localparam int unsigned C_B_QCPASS     = 4;
  localparam int unsigned C_B_QCFAIL     = 5;
  localparam int unsigned C_B_PAIRED     = 6;
  localparam int unsigned C_B_SINGLE     = 7;
  localparam int unsigned C_R_DUP        = 8;
  localparam int unsigned C_R_ALIGNED    = 9;
  localparam int unsigned C_R_MAPPED     = 10;
  localparam int unsigned C_B_DUP        = 11;
  localparam int unsigned C_B_ALIGNED    = 12;
  localparam int unsigned C_B_MAPPED     = 13;
  localparam int unsigned C_READ1        = 14;
  localparam int unsigned C_READ2        = 15;
  localparam int unsigned C_PROPER       = 16;
  localparam int unsigned C_BOTHALIGNED  = 17;

  typedef enum logic [1:0] {
    ADD_ONE  = 2'd0,
    ADD_RLEN = 2'd1,
    ADD_USED = 2'd2
  } add_e;

  // What each counter accumulates when it is enabled.
  function automatic add_e counter_addend(input int unsigned idx);
    add_e kind;
    kind = ADD_ONE;
    if (idx == C_B_QCPASS || idx == C_B_QCFAIL || idx == C_B_PAIRED ||
        idx == C_B_SINGLE) begin
      kind = ADD_RLEN;
    end else if (idx == C_B_DUP || idx == C_B_ALIGNED || idx == C_B_MAPPED) begin
      kind = ADD_USED;
    end
    return kind;
  endfunction

  // Counter update request from the record evaluator to the counter bank.
  typedef struct packed {
    logic [NUM_COUNTERS-1:0] inc;
    logic [RLEN_W-1:0]       rlen;
    logic [SUM_W-1:0]        used;
  } upd_t;

endpackage

`default_nettype wire

// File: hdl/alignment_flag_statistics_unit.sv
// ---------------------------------------------------------------------------
// alignment_flag_statistics_unit
// Alignment record statistics: cigar accumulation, flag based counters and
// counter readout.
// ---------------------------------------------------------------------------
// The unit takes one request per cycle while the output side does not stall
// and returns exactly one result per request. Each request is held in an
// input register; from there a single stage of flag decode and parallel
// 64-bit counter adds produces the result register and updates the counters,
// the cigar sum and the pending cigar error in the same cycle. Cigar elements
// must precede their record header, and a counter read returns the value
// after all earlier requests. Counters wrap at 2^64 and reset to zero.
`default_nettype none

module alignment_flag_statistics_unit
  import afs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OP_W-1:0]     op_i,
  input  wire logic [CODE_W-1:0]   cigar_code_i,
  input  wire logic [CLEN_W-1:0]   cigar_length_i,
  input  wire logic [FLAGS_W-1:0]  flags_i,
  input  wire logic [RLEN_W-1:0]   read_length_i,
  input  wire logic [MAPQ_W-1:0]   mapping_quality_i,
  input  wire logic [IDX_W-1:0]    counter_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               status_o,
  output logic                     counted_o,
  output logic [CNT_W-1:0]         counter_value_o
);

  // Input register.
  logic                in_valid_q, in_valid_d;
  op_e                 op_q;
  logic [CODE_W-1:0]   code_q;
  logic [CLEN_W-1:0]   clen_q;
  logic [FLAGS_W-1:0]  flags_q;
  logic [RLEN_W-1:0]   rlen_q;
  logic [MAPQ_W-1:0]   mapq_q;
  logic [IDX_W-1:0]    idx_q;

  // Cigar state.
  logic [SUM_W-1:0]    sum_q, sum_d;
  status_e             pend_q, pend_d;

  // Result register.
  logic                out_valid_q, out_valid_d;
  status_e             status_q, status_d;
  logic                counted_q, counted_d;
  logic [CNT_W-1:0]    value_q, value_d;

  logic                advance, in_take;
  upd_t                upd, upd_gated;
  status_e             rec_status;
  logic                rec_counted;
  logic [CNT_W-1:0]    rd_data;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  afs_record_eval u_eval (
    .en_i              (op_q == OP_RECORD),
    .flags_i           (flags_q),
    .read_length_i     (rlen_q),
    .mapping_quality_i (mapq_q),
    .used_sum_i        (sum_q),
    .pending_i         (pend_q),
    .upd_o             (upd),
    .status_o          (rec_status),
    .counted_o         (rec_counted)
  );

  always_comb begin
    upd_gated     = upd;
    upd_gated.inc = advance ? upd.inc : '0;
  end

  afs_counter_bank u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (upd_gated),
    .rd_idx_i  (idx_q),
    .rd_data_o (rd_data)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Cigar sum and pending error; the first error in cigar order is kept.
  always_comb begin
    sum_d  = sum_q;
    pend_d = pend_q;
    if (advance) begin
      unique case (op_q)
        OP_CIGAR: begin
          if (code_q == CIG_MATCH || code_q == CIG_INSERT) begin
            sum_d = sum_q + SUM_W'(clen_q);
          end else if (code_q == CIG_SKIP && pend_q == ST_OK) begin
            pend_d = ST_SKIP;
          end else if (code_q > CIG_PAD && pend_q == ST_OK) begin
            pend_d = ST_BAD_OP;
          end
        end
        OP_RECORD: begin
          sum_d  = '0;
          pend_d = ST_OK;
        end
        default: begin
          sum_d  = sum_q;
          pend_d = pend_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    status_d  = ST_OK;
    counted_d = 1'b0;
    value_d   = '0;
    unique case (op_q)
      OP_RECORD: begin
        status_d  = rec_status;
        counted_d = rec_counted;
      end
      OP_READ: begin
        value_d = rd_data;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      pend_q      <= ST_OK;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= op_e'(op_i);
      code_q  <= cigar_code_i;
      clen_q  <= cigar_length_i;
      flags_q <= flags_i;
      rlen_q  <= read_length_i;
      mapq_q  <= mapping_quality_i;
      idx_q   <= counter_index_i;
    end
    if (advance) begin
      status_q  <= status_d;
      counted_q <= counted_d;
      value_q   <= value_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign counted_o       = counted_q;
  assign counter_value_o = value_q;

endmodule

`default_nettype wire

// File: hdl/afs_record_eval.sv
// ---------------------------------------------------------------------------
// afs_record_eval
// Decides the outcome of a record header: which counters move, the status
// and whether the record was counted.
// ---------------------------------------------------------------------------
`default_nettype none

module afs_record_eval
  import afs_pkg::*;
(
  input  wire logic                en_i,
  input  wire logic [FLAGS_W-1:0]  flags_i,
  input  wire logic [RLEN_W-1:0]   read_length_i,
  input  wire logic [MAPQ_W-1:0]   mapping_quality_i,
  input  wire logic [SUM_W-1:0]    used_sum_i,
  input  status_e                  pending_i,
  output upd_t                     upd_o,
  output status_e                  status_o,
  output logic                     counted_o
);

  logic filtered, qcfail, paired, mapped, no_frag, cig_err, full, aln;

  always_comb begin
    filtered = (read_length_i == '0) || flags_i[FL_SECONDARY] || flags_i[FL_SUPPL];
    qcfail   = flags_i[FL_QCFAIL];
    paired   = flags_i[FL_PAIRED];
    mapped   = !flags_i[FL_UNMAPPED];
    no_frag  = paired && !flags_i[FL_READ1] && !flags_i[FL_READ2];
    cig_err  = mapped && (pending_i != ST_OK);
    full     = en_i && !filtered && !qcfail && !no_frag && !cig_err;
    aln      = full && mapped;
  end

  always_comb begin
    upd_o      = '0;
    upd_o.rlen = read_length_i;
    upd_o.used = used_sum_i;

    upd_o.inc[C_R_QCFAIL] = en_i && !filtered && qcfail;
    upd_o.inc[C_B_QCFAIL] = en_i && !filtered && qcfail;

    upd_o.inc[C_R_QCPASS] = full;
    upd_o.inc[C_B_QCPASS] = full;
    upd_o.inc[C_R_SINGLE] = full && !paired;
    upd_o.inc[C_B_SINGLE] = full && !paired;
    upd_o.inc[C_R_PAIRED] = full && paired;
    upd_o.inc[C_B_PAIRED] = full && paired;
    // A record carrying both fragment marks counts as read1.
    upd_o.inc[C_READ1]    = full && paired && flags_i[FL_READ1];
    upd_o.inc[C_READ2]    = full && paired && !flags_i[FL_READ1];

    upd_o.inc[C_R_ALIGNED] = aln;
    upd_o.inc[C_B_ALIGNED] = aln;
    upd_o.inc[C_R_MAPPED]  = aln && (mapping_quality_i != '0) &&
                             (mapping_quality_i != MAPQ_UNKNOWN);
    upd_o.inc[C_B_MAPPED]  = upd_o.inc[C_R_MAPPED];
    upd_o.inc[C_R_DUP]     = aln && flags_i[FL_DUP];
    upd_o.inc[C_B_DUP]     = aln && flags_i[FL_DUP];
    upd_o.inc[C_PROPER]    = aln && paired && flags_i[FL_PROPER];
    upd_o.inc[C_BOTHALIGNED] = aln && paired &&
                               (flags_i[FL_PROPER] || !flags_i[FL_MATE_UNMAPPED]);
  end

  always_comb begin
    status_o  = ST_OK;
    counted_o = 1'b0;
    priority if (!en_i || filtered) begin
      status_o  = ST_OK;
      counted_o = 1'b0;
    end else if (qcfail) begin
      counted_o = 1'b1;
    end else if (no_frag) begin
      status_o = ST_NO_FRAG;
    end else if (cig_err) begin
      status_o = pending_i;
    end else begin
      counted_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hdl/afs_counter_bank.sv
// ---------------------------------------------------------------------------
// afs_counter_bank
// Eighteen wrapping 64-bit statistics counters with one read port.
// ---------------------------------------------------------------------------
`default_nettype none

module afs_counter_bank
  import afs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  upd_t                   upd_i,
  input  wire logic [IDX_W-1:0]  rd_idx_i,
  output logic [CNT_W-1:0]       rd_data_o
);

  logic [CNT_W-1:0] cnt_q [NUM_COUNTERS];
  logic [CNT_W-1:0] cnt_d [NUM_COUNTERS];

  for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_cnt
    logic [CNT_W-1:0] addend;

    always_comb begin
      unique case (counter_addend(i))
        ADD_RLEN: addend = CNT_W'(upd_i.rlen);
        ADD_USED: addend = CNT_W'(upd_i.used);
        default:  addend = CNT_W'(1);
      endcase
      cnt_d[i] = upd_i.inc[i] ? cnt_q[i] + addend : cnt_q[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[i] <= '0;
      end else begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  always_comb begin
    rd_data_o = '0;
    for (int unsigned k = 0; k < NUM_COUNTERS; k++) begin
      if (rd_idx_i == IDX_W'(k)) begin
        rd_data_o = cnt_q[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/afs_checker.sv
// ---------------------------------------------------------------------------
// afs_checker
// Port level assertions for the alignment flag statistics unit.
// ---------------------------------------------------------------------------
`default_nettype none

`include "alignment_flag_statistics_unit_assert.svh"

module afs_checker
  import afs_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [1:0]          status_o,
  input wire logic                counted_o,
  input wire logic [CNT_W-1:0]    counter_value_o
);

  logic             out_held;
  logic [CNT_W+3:0] out_view;
  logic             out_counted;
  logic             status_ok;
  logic             out_value;
  logic             read_like;

  assign out_held    = out_valid_o && out_stall_i;
  assign out_view    = {out_valid_o, status_o, counted_o, counter_value_o};
  assign out_counted = out_valid_o && counted_o;
  assign status_ok   = (status_o == ST_OK);
  assign out_value   = out_valid_o && (counter_value_o != '0);
  assign read_like   = !counted_o && status_ok;

  // A result that is held back keeps its payload.
  `AFS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, $stable(out_view), "held result changed")

  // A counted record never carries an error status.
  `AFS_ASSERT_IMP(a_counted_ok, clk_i, rst_ni, out_counted, status_ok, "counted with an error")

  // Only counter reads return a value, and they carry no record outcome.
  `AFS_ASSERT_IMP(a_value_read, clk_i, rst_ni, out_value, read_like, "value on a non-read result")

  // With an empty result register the unit always takes a request.
  `AFS_ASSERT_IMP(a_no_idle_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o, "idle input stall")

endmodule

bind alignment_flag_statistics_unit afs_checker u_afs_checker (.*);

`default_nettype wire

// File: verif/alignment_flag_statistics_unit_checker.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// alignment_flag_statistics_unit_checker
// Watches the request and result channels of the statistics unit, keeps its own copy of
// the counter bank and the cigar state, and compares every result in order.
// ----------------------------------------------------------------------------

module alignment_flag_statistics_unit_checker
  import afs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [OP_W-1:0]    op_i,
  input  logic [CODE_W-1:0]  cigar_code_i,
  input  logic [CLEN_W-1:0]  cigar_length_i,
  input  logic [FLAGS_W-1:0] flags_i,
  input  logic [RLEN_W-1:0]  read_length_i,
  input  logic [MAPQ_W-1:0]  mapping_quality_i,
  input  logic [IDX_W-1:0]   counter_index_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic               counted_i,
  input  logic [CNT_W-1:0]   counter_value_i,
  output int                 mismatch_count_o,
  output int                 outstanding_o,
  output int                 records_counted_o,
  output int                 records_rejected_o,
  output int                 counter_reads_o
);

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef struct packed {
    status_e          status;
    logic             counted;
    logic [CNT_W-1:0] value;
  } flagstat_result_t;

  logic [CNT_W-1:0] stat_bank [NUM_COUNTERS];
  logic [SUM_W-1:0] used_bases;
  status_e          cigar_error;
  flagstat_result_t awaited_results [$];
  flagstat_result_t oldest;

  // Applies one request to the shadow state and returns the result it causes.
  function automatic flagstat_result_t predict_flagstat(
    input logic [OP_W-1:0]    op,
    input logic [CODE_W-1:0]  code,
    input logic [CLEN_W-1:0]  len,
    input logic [FLAGS_W-1:0] flags,
    input logic [RLEN_W-1:0]  rlen,
    input logic [MAPQ_W-1:0]  mapq,
    input logic [IDX_W-1:0]   idx
  );
    flagstat_result_t res;
    logic             paired;
    logic             mapped;
    logic [CNT_W-1:0] rlen64;
    logic [CNT_W-1:0] used64;
    res.status  = ST_OK;
    res.counted = 1'b0;
    res.value   = '0;
    paired = flags[FL_PAIRED];
    mapped = !flags[FL_UNMAPPED];
    rlen64 = CNT_W'(rlen);
    used64 = CNT_W'(used_bases);
    case (op)
      OP_CIGAR: begin
        if (code == CIG_MATCH || code == CIG_INSERT) begin
          used_bases = used_bases + SUM_W'(len);
        end else if (code == CIG_SKIP && cigar_error == ST_OK) begin
          cigar_error = ST_SKIP;
        end else if (code > CIG_PAD && cigar_error == ST_OK) begin
          cigar_error = ST_BAD_OP;
        end
      end
      OP_RECORD: begin
        if (rlen == '0 || flags[FL_SECONDARY] || flags[FL_SUPPL]) begin
          res.counted = 1'b0;
        end else if (flags[FL_QCFAIL]) begin
          // A failed read only feeds the qc-failed pair and ignores the cigar.
          stat_bank[C_R_QCFAIL] += CNT_ONE;
          stat_bank[C_B_QCFAIL] += rlen64;
          res.counted = 1'b1;
        end else if (paired && !flags[FL_READ1] && !flags[FL_READ2]) begin
          res.status = ST_NO_FRAG;
        end else if (mapped && cigar_error != ST_OK) begin
          res.status = cigar_error;
        end else begin
          res.counted = 1'b1;
          stat_bank[C_R_QCPASS] += CNT_ONE;
          stat_bank[C_B_QCPASS] += rlen64;
          if (!paired) begin
            stat_bank[C_R_SINGLE] += CNT_ONE;
            stat_bank[C_B_SINGLE] += rlen64;
          end else begin
            stat_bank[C_R_PAIRED] += CNT_ONE;
            stat_bank[C_B_PAIRED] += rlen64;
            if (flags[FL_READ1]) begin
              stat_bank[C_READ1] += CNT_ONE;
            end else begin
              stat_bank[C_READ2] += CNT_ONE;
            end
          end
          if (mapped) begin
            stat_bank[C_R_ALIGNED] += CNT_ONE;
            stat_bank[C_B_ALIGNED] += used64;
            if (mapq != '0 && mapq != MAPQ_UNKNOWN) begin
              stat_bank[C_R_MAPPED] += CNT_ONE;
              stat_bank[C_B_MAPPED] += used64;
            end
            if (flags[FL_DUP]) begin
              stat_bank[C_R_DUP] += CNT_ONE;
              stat_bank[C_B_DUP] += used64;
            end
            if (paired && flags[FL_PROPER]) begin
              stat_bank[C_PROPER] += CNT_ONE;
              stat_bank[C_BOTHALIGNED] += CNT_ONE;
            end else if (paired && !flags[FL_MATE_UNMAPPED]) begin
              stat_bank[C_BOTHALIGNED] += CNT_ONE;
            end
          end
        end
        // Every header closes its cigar, whatever became of the record.
        used_bases  = '0;
        cigar_error = ST_OK;
      end
      OP_READ: begin
        if (idx < NUM_COUNTERS) begin
          res.value = stat_bank[idx];
        end
      end
      default: begin
        res.counted = 1'b0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COUNTERS; i++) stat_bank[i] = '0;
      used_bases  = '0;
      cigar_error = ST_OK;
      awaited_results.delete();
      mismatch_count_o   = 0;
      records_counted_o  = 0;
      records_rejected_o = 0;
      counter_reads_o    = 0;
      outstanding_o     <= 0;
    end else begin
      // Results are retired before the request of the same edge is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          mismatch_count_o++;
          $error("result with no request waiting: status %0d counted %0d value %0h",
                 status_i, counted_i, counter_value_i);
        end else begin
          oldest = awaited_results.pop_front();
          if (status_i !== oldest.status) begin
            mismatch_count_o++;
            $error("status: expected %0d, actual %0d", oldest.status, status_i);
          end
          if (counted_i !== oldest.counted) begin
            mismatch_count_o++;
            $error("counted: expected %0d, actual %0d", oldest.counted, counted_i);
          end
          if (counter_value_i !== oldest.value) begin
            mismatch_count_o++;
            $error("counter_value: expected %0h, actual %0h", oldest.value,
                   counter_value_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        oldest = predict_flagstat(op_i, cigar_code_i, cigar_length_i, flags_i,
                                  read_length_i, mapping_quality_i, counter_index_i);
        awaited_results.push_back(oldest);
        if (oldest.counted) records_counted_o++;
        if (op_i == OP_RECORD && oldest.status != ST_OK) records_rejected_o++;
        if (op_i == OP_READ) counter_reads_o++;
      end
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

// File: verif/alignment_flag_statistics_unit_test.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// alignment_flag_statistics_unit_test
// Drives cigar elements, record headers and counter reads into the statistics
// unit with random gaps and output stalls; the checker scores every result.
// ----------------------------------------------------------------------------

module alignment_flag_statistics_unit_test;
  import afs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 400;
  localparam int unsigned RANDOM_ITEMS   = 1300;
  localparam int unsigned DRAIN_CYCLES   = 10;

  localparam logic [CODE_W-1:0]  CIG_DELETE       = 4'd2;
  localparam logic [CODE_W-1:0]  CIG_SOFT         = 4'd4;
  localparam logic [CODE_W-1:0]  CIG_HARD         = 4'd5;
  localparam logic [CODE_W-1:0]  CIG_FIRST_UNKNWN = 4'd7;
  localparam logic [CODE_W-1:0]  CIG_LAST_UNKNWN  = 4'd15;
  localparam logic [CLEN_W-1:0]  CLEN_MAX         = {CLEN_W{1'b1}};
  localparam logic [RLEN_W-1:0]  RLEN_MAX         = {RLEN_W{1'b1}};
  localparam logic [IDX_W-1:0]   IDX_MAX          = {IDX_W{1'b1}};

  localparam logic [FLAGS_W-1:0] F_PAIRED   = FLAGS_W'(1) << FL_PAIRED;
  localparam logic [FLAGS_W-1:0] F_PROPER   = FLAGS_W'(1) << FL_PROPER;
  localparam logic [FLAGS_W-1:0] F_UNMAPPED = FLAGS_W'(1) << FL_UNMAPPED;
  localparam logic [FLAGS_W-1:0] F_MATE_UNM = FLAGS_W'(1) << FL_MATE_UNMAPPED;
  localparam logic [FLAGS_W-1:0] F_READ1    = FLAGS_W'(1) << FL_READ1;
  localparam logic [FLAGS_W-1:0] F_READ2    = FLAGS_W'(1) << FL_READ2;
  localparam logic [FLAGS_W-1:0] F_SECOND   = FLAGS_W'(1) << FL_SECONDARY;
  localparam logic [FLAGS_W-1:0] F_QCFAIL   = FLAGS_W'(1) << FL_QCFAIL;
  localparam logic [FLAGS_W-1:0] F_DUP      = FLAGS_W'(1) << FL_DUP;
  localparam logic [FLAGS_W-1:0] F_SUPPL    = FLAGS_W'(1) << FL_SUPPL;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [OP_W-1:0]    op_i;
  logic [CODE_W-1:0]  cigar_code_i;
  logic [CLEN_W-1:0]  cigar_length_i;
  logic [FLAGS_W-1:0] flags_i;
  logic [RLEN_W-1:0]  read_length_i;
  logic [MAPQ_W-1:0]  mapping_quality_i;
  logic [IDX_W-1:0]   counter_index_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic               counted_o;
  logic [CNT_W-1:0]   counter_value_o;

  int mismatches;
  int outstanding;
  int records_counted;
  int records_rejected;
  int counter_reads;
  int requests_sent;
  int stall_left;
  int stuck_cycles;
  bit quiet;

  alignment_flag_statistics_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .cigar_code_i      (cigar_code_i),
    .cigar_length_i    (cigar_length_i),
    .flags_i           (flags_i),
    .read_length_i     (read_length_i),
    .mapping_quality_i (mapping_quality_i),
    .counter_index_i   (counter_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .counted_o         (counted_o),
    .counter_value_o   (counter_value_o)
  );

  alignment_flag_statistics_unit_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .op_i               (op_i),
    .cigar_code_i       (cigar_code_i),
    .cigar_length_i     (cigar_length_i),
    .flags_i            (flags_i),
    .read_length_i      (read_length_i),
    .mapping_quality_i  (mapping_quality_i),
    .counter_index_i    (counter_index_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_i           (status_o),
    .counted_i          (counted_o),
    .counter_value_i    (counter_value_o),
    .mismatch_count_o   (mismatches),
    .outstanding_o      (outstanding),
    .records_counted_o  (records_counted),
    .records_rejected_o (records_rejected),
    .counter_reads_o    (counter_reads)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The receiver stalls for a freshly drawn number of cycles after each result.
  initial begin
    out_stall_i <= 1'b0;
    stall_left   = 0;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      stall_left   = quiet ? 0 : $urandom_range(8);
      out_stall_i <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left   = stall_left - 1;
      out_stall_i <= (stall_left != 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL alignment_flag_statistics_unit");
      $finish;
    end
  end

  // Offers one request after a random gap and returns at the edge that takes it.
  task automatic send_request(input op_e op, input logic [CODE_W-1:0] code,
                              input logic [CLEN_W-1:0] len,
                              input logic [FLAGS_W-1:0] flags,
                              input logic [RLEN_W-1:0] rlen,
                              input logic [MAPQ_W-1:0] mapq,
                              input logic [IDX_W-1:0] idx);
    int gap;
    gap = quiet ? 0 : $urandom_range(8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    op_i              <= op;
    cigar_code_i      <= code;
    cigar_length_i    <= len;
    flags_i           <= flags;
    read_length_i     <= rlen;
    mapping_quality_i <= mapq;
    counter_index_i   <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op != OP_NONE) requests_sent++;
  endtask

  // Fields a request does not use carry random values.
  task automatic send_cigar(input logic [CODE_W-1:0] code, input logic [CLEN_W-1:0] len);
    send_request(OP_CIGAR, code, len, FLAGS_W'($urandom), RLEN_W'($urandom),
                 MAPQ_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic send_record(input logic [FLAGS_W-1:0] flags,
                             input logic [RLEN_W-1:0] rlen,
                             input logic [MAPQ_W-1:0] mapq);
    send_request(OP_RECORD, CODE_W'($urandom), CLEN_W'($urandom), flags, rlen, mapq,
                 IDX_W'($urandom));
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    send_request(OP_READ, CODE_W'($urandom), CLEN_W'($urandom), FLAGS_W'($urandom),
                 RLEN_W'($urandom), MAPQ_W'($urandom), idx);
  endtask

  // A request of the unused kind with every field random.
  task automatic send_unused;
    send_request(OP_NONE, CODE_W'($urandom), CLEN_W'($urandom), FLAGS_W'($urandom),
                 RLEN_W'($urandom), MAPQ_W'($urandom), IDX_W'($urandom));
  endtask

  // The outstanding count is registered, so the task lets it catch up with the last request before polling it.
  task automatic wait_for_results;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    int                 n_elems;
    int                 pick;
    int                 next_phase;
    bit                 long_cigar;
    bit                 drained;
    logic [CODE_W-1:0]  code;
    logic [CLEN_W-1:0]  len;
    logic [FLAGS_W-1:0] flags;
    logic [RLEN_W-1:0]  rlen;
    logic [MAPQ_W-1:0]  mapq;

    rst_ni            <= 1'b0;
    in_valid_i        <= 1'b0;
    op_i              <= OP_NONE;
    cigar_code_i      <= '0;
    cigar_length_i    <= '0;
    flags_i           <= '0;
    read_length_i     <= '0;
    mapping_quality_i <= '0;
    counter_index_i   <= '0;
    quiet         = 1'b0;
    drained       = 1'b0;
    requests_sent = 0;
    next_phase    = 100;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty bank, field extremes and each record outcome.
    send_read(IDX_W'(C_R_QCPASS));
    send_read(IDX_MAX);
    send_cigar(CIG_MATCH, CLEN_MAX);
    send_cigar(CIG_INSERT, CLEN_MAX);
    send_cigar(CIG_DELETE, CLEN_MAX);
    send_cigar(CIG_SOFT, '0);
    send_cigar(CIG_HARD, '0);
    send_cigar(CIG_PAD, CLEN_MAX);
    send_record(F_DUP, RLEN_MAX, 8'd60);
    send_read(IDX_W'(C_B_ALIGNED));
    // The first cigar error of a record is the one reported.
    send_cigar(CIG_SKIP, 28'd5);
    send_cigar(CIG_LAST_UNKNWN, 28'd5);
    send_record('0, 16'd100, 8'd30);
    send_cigar(CIG_FIRST_UNKNWN, 28'd1);
    send_record(F_PAIRED | F_READ1 | F_PROPER, 16'd100, 8'd30);
    // An unmapped or qc-failed record ignores a pending cigar error.
    send_cigar(CIG_SKIP, 28'd1);
    send_record(F_UNMAPPED | F_PAIRED | F_READ2, 16'd1, 8'd0);
    send_cigar(CIG_SKIP, 28'd1);
    send_record(F_QCFAIL, RLEN_MAX, MAPQ_UNKNOWN);
    send_record('0, '0, 8'd10);
    send_record(F_SECOND, 16'd50, 8'd10);
    send_record(F_SUPPL, 16'd50, 8'd10);
    send_record(F_PAIRED, 16'd50, 8'd10);
    send_cigar(CIG_MATCH, 28'd100);
    send_record(F_PAIRED | F_READ1 | F_READ2 | F_PROPER, 16'd120, MAPQ_UNKNOWN);
    send_record(F_PAIRED | F_READ2 | F_MATE_UNM, 16'd80, '0);
    send_unused();
    send_read(IDX_W'(C_READ1));

    while (requests_sent < RANDOM_ITEMS) begin
      if (requests_sent >= next_phase) begin
        quiet      = ($urandom_range(3) == 0);
        next_phase = next_phase + 100;
      end
      if (!drained && requests_sent >= RANDOM_ITEMS / 2) begin
        wait_for_results();
        drained = 1'b1;
      end
      pick = $urandom_range(15);
      if (pick < 11) begin
        // A record: its cigar elements, then the header.
        long_cigar = ($urandom_range(15) == 0);
        n_elems = long_cigar ? $urandom_range(17, 24) : $urandom_range(6);
        repeat (n_elems) begin
          pick = $urandom_range(19);
          if (pick < 12) code = CODE_W'($urandom_range(CIG_INSERT));
          else if (pick == 12) code = CIG_DELETE;
          else if (pick < 18) code = CODE_W'($urandom_range(CIG_SOFT, CIG_PAD));
          else if (pick == 18) code = CIG_SKIP;
          else code = CODE_W'($urandom_range(CIG_FIRST_UNKNWN, CIG_LAST_UNKNWN));
          if (long_cigar || $urandom_range(7) == 0) len = CLEN_W'($urandom);
          else len = CLEN_W'($urandom_range(300));
          send_cigar(code, len);
        end
        flags = FLAGS_W'($urandom);
        if ($urandom_range(7) != 0) begin
          flags[FL_SECONDARY] = 1'b0;
          flags[FL_SUPPL]     = 1'b0;
        end
        if ($urandom_range(5) != 0) flags[FL_QCFAIL] = 1'b0;
        if ($urandom_range(3) != 0) flags[FL_UNMAPPED] = 1'b0;
        if (flags[FL_PAIRED] && !flags[FL_READ1] && !flags[FL_READ2] &&
            $urandom_range(7) != 0) begin
          flags[FL_READ1 + $urandom_range(1)] = 1'b1;
        end
        pick = $urandom_range(15);
        if (pick == 0) rlen = '0;
        else if (pick == 1) rlen = RLEN_MAX;
        else if (pick < 8) rlen = RLEN_W'($urandom);
        else rlen = RLEN_W'($urandom_range(1, 500));
        pick = $urandom_range(7);
        if (pick == 0) mapq = '0;
        else if (pick == 1) mapq = MAPQ_UNKNOWN;
        else mapq = MAPQ_W'($urandom);
        send_record(flags, rlen, mapq);
      end else if (pick < 14) begin
        send_read(IDX_W'($urandom));
      end else if (pick == 14) begin
        send_unused();
      end else begin
        // Noise: a stray request of any used kind with every field random.
        send_request(op_e'($urandom_range(OP_READ)), CODE_W'($urandom),
                     CLEN_W'($urandom), FLAGS_W'($urandom), RLEN_W'($urandom),
                     MAPQ_W'($urandom), IDX_W'($urandom));
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests, including %0d counter reads, with random gaps and stalls.",
             requests_sent, counter_reads);
    $display("Records counted: %0d, records rejected with an error status: %0d.",
             records_counted, records_rejected);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS alignment_flag_statistics_unit");
    end else begin
      $display("FAIL alignment_flag_statistics_unit");
    end
    $finish;
  end

endmodule
